// File: rtl/core/a64d_pkg.sv
// Shared types and constants for the AArch64 subset instruction decoder.
package a64d_pkg;

  // Instruction word and result field widths
  localparam int unsigned InstrW  = 32;
  localparam int unsigned RegW    = 5;
  localparam int unsigned ImmW    = 26;
  localparam int unsigned SubOpW  = 4;
  localparam int unsigned ShSelW  = 2;
  localparam int unsigned ShAmtW  = 6;
  localparam int unsigned KindW   = 4;
  localparam int unsigned TdataOW = 64;

  // The one exact no-operation word
  localparam logic [InstrW-1:0] NopWord = 32'hD503_201F;

  // Decoded instruction kind
  typedef enum logic [KindW-1:0] {
    KIND_INVALID = 4'd0,
    KIND_NOP     = 4'd1,
    KIND_ADDIMM  = 4'd2,
    KIND_MOVWIDE = 4'd3,
    KIND_LOGREG  = 4'd4,
    KIND_ADDREG  = 4'd5,
    KIND_MUL     = 4'd6,
    KIND_BIMM    = 4'd7,
    KIND_BCOND   = 4'd8,
    KIND_BREG    = 4'd9,
    KIND_LDLIT   = 4'd10,
    KIND_LSREG   = 4'd11,
    KIND_LSUIMM  = 4'd12,
    KIND_LSSIMM  = 4'd13
  } a64d_kind_e;

  // Flat decode record
  typedef struct packed {
    a64d_kind_e          kind;
    logic                wide;
    logic [RegW-1:0]     rd;
    logic [RegW-1:0]     rn;
    logic [RegW-1:0]     rm;
    logic [RegW-1:0]     ra;
    logic [ImmW-1:0]     immediate;
    logic [SubOpW-1:0]   sub_op;
    logic [ShSelW-1:0]   shift_sel;
    logic                flag_a;
    logic                flag_b;
    logic [ShAmtW-1:0]   shamt;
  } a64d_rec_t;

endpackage

// File: rtl/core/a64d_decode.sv
// Combinational decode of one instruction word into a flat record.
module a64d_decode (
  input  logic [a64d_pkg::InstrW-1:0] word_i,
  output a64d_pkg::a64d_rec_t         rec_o
);
  import a64d_pkg::*;

  logic [3:0] cls;
  logic [2:0] imm_op;
  logic       op1, b3, b0;
  logic [2:0] br_op;
  logic [1:0] ls_op0, ls_op2, ls_op4;
  logic       ls_op3;
  a64d_rec_t  rec;

  assign cls    = word_i[28:25];
  assign imm_op = word_i[25:23];
  assign op1    = word_i[28];
  assign b3     = word_i[24];
  assign b0     = word_i[21];
  assign br_op  = word_i[31:29];
  assign ls_op0 = word_i[29:28];
  assign ls_op2 = word_i[24:23];
  assign ls_op3 = word_i[21];
  assign ls_op4 = word_i[11:10];

  // Classify the word and pull out the fields of its kind
  always_comb begin
    rec = '0;
    if (word_i == NopWord) begin
      rec.kind = KIND_NOP;
    end else if (cls[3:1] == 3'b100) begin
      // data processing, immediate
      if (imm_op == 3'b010) begin
        rec.kind      = KIND_ADDIMM;
        rec.flag_a    = word_i[30];
        rec.flag_b    = word_i[29];
        rec.shift_sel = {1'b0, word_i[22]};
        rec.immediate = {14'd0, word_i[21:10]};
        rec.rn        = word_i[9:5];
      end else if (imm_op == 3'b101) begin
        rec.kind      = KIND_MOVWIDE;
        rec.immediate = {10'd0, word_i[20:5]};
        rec.sub_op    = {2'b00, word_i[30:29]};
        rec.shift_sel = word_i[22:21];
      end
      rec.wide = word_i[31];
      rec.rd   = word_i[4:0];
    end else if (cls[2:0] == 3'b101) begin
      // data processing, register
      if (op1 && b3) begin
        rec.kind   = KIND_MUL;
        rec.ra     = word_i[14:10];
        rec.flag_a = word_i[15];
      end else if (!op1 && !b3) begin
        rec.kind      = KIND_LOGREG;
        rec.sub_op    = {2'b00, word_i[30:29]};
        rec.flag_a    = word_i[21];
        rec.shamt     = word_i[15:10];
        rec.shift_sel = word_i[23:22];
      end else if (!b0 && b3) begin
        rec.kind      = KIND_ADDREG;
        rec.flag_a    = word_i[30];
        rec.flag_b    = word_i[29];
        rec.shift_sel = word_i[23:22];
        rec.shamt     = word_i[15:10];
      end
      rec.wide = word_i[31];
      rec.rm   = word_i[20:16];
      rec.rn   = word_i[9:5];
      rec.rd   = word_i[4:0];
    end else if (cls[3:1] == 3'b101) begin
      // branches
      if (br_op == 3'b010) begin
        rec.kind      = KIND_BCOND;
        rec.sub_op    = word_i[3:0];
        rec.immediate = {7'd0, word_i[23:5]};
      end else if (br_op[1:0] == 2'b00) begin
        rec.kind      = KIND_BIMM;
        rec.immediate = word_i[25:0];
      end else if (br_op == 3'b110) begin
        rec.kind = KIND_BREG;
        rec.rn   = word_i[9:5];
      end
    end else if (!cls[0] && cls[2]) begin
      // loads and stores
      if (ls_op0 == 2'b01 && !ls_op2[1]) begin
        rec.kind      = KIND_LDLIT;
        rec.immediate = {7'd0, word_i[23:5]};
      end else if (ls_op0 == 2'b11 && ls_op4 == 2'b10 && ls_op3 && !ls_op2[1]) begin
        rec.kind   = KIND_LSREG;
        rec.sub_op = {1'b0, word_i[15:13]};
        rec.flag_b = word_i[12];
        rec.rn     = word_i[9:5];
        rec.rm     = word_i[20:16];
        rec.flag_a = word_i[22];
      end else if (ls_op0 == 2'b11 && ls_op2[1]) begin
        rec.kind      = KIND_LSUIMM;
        rec.immediate = {14'd0, word_i[21:10]};
        rec.rn        = word_i[9:5];
        rec.flag_a    = word_i[22];
      end else if (ls_op0 == 2'b11 && !ls_op3) begin
        rec.kind      = KIND_LSSIMM;
        rec.immediate = {17'd0, word_i[20:12]};
        rec.rn        = word_i[9:5];
        rec.flag_a    = word_i[22];
        rec.shift_sel = word_i[11:10];
      end
      rec.wide = word_i[30];
      rec.rd   = word_i[4:0];
    end
    // Clear every field of an unmatched encoding
    if (rec.kind == KIND_INVALID) begin
      rec = '0;
    end
  end

  assign rec_o = rec;

endmodule

// File: rtl/core/arm64_subset_instruction_decoder_unit.sv
// Top level of the AArch64 subset instruction decoder with its stream ports.
// An accepted input beat passes through the input word register, then the result register.
// Throughput: one instruction word per cycle while the result side is not stalled; decode
// is a single combinational pass between the input word register and the result register.
// Reset: rst_ni clears both valid flags asynchronously; payload is not reset.
// Each stage advances whenever the stage after it is empty or draining.
module arm64_subset_instruction_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: instr_word[31:0]
  input  logic [a64d_pkg::InstrW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: wide[0], rd[5:1], rn[10:6], rm[15:11], ra[20:16], immediate[46:21],
  //        sub_op[50:47], shift_sel[52:51], flag_a[53], flag_b[54],
  //        shamt[60:55], zero fill[63:61]
  output logic [a64d_pkg::TdataOW-1:0]  m_axis_tdata_o,
  // tuser: kind[3:0]
  output logic [a64d_pkg::KindW-1:0]    m_axis_tuser_o
);
  import a64d_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [InstrW-1:0] s1_word_q, s1_word_d;
  logic              out_valid_q, out_valid_d;
  a64d_rec_t         out_rec_q, out_rec_d;
  logic              out_adv;
  logic              s1_adv;
  logic              in_acc;

  // Advance a stage when its successor is free or is handing off a beat
  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && out_adv;
  assign s_axis_tready_o = !s1_valid_q || out_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  a64d_decode u_decode (
    .word_i (s1_word_q),
    .rec_o  (out_rec_d)
  );

  // Next-state logic for both stages
  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_word_d   = s1_word_q;
    out_valid_d = out_valid_q;
    if (s_axis_tready_o) begin
      s1_valid_d = s_axis_tvalid_i;
      s1_word_d  = s_axis_tdata_i;
    end
    if (out_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  // Hold valid flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load payload registers on accepted beats only
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= s1_word_d;
    end
    if (s1_adv) begin
      out_rec_q <= out_rec_d;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_rec_q.kind;
  assign m_axis_tdata_o  = {3'b000,
                            out_rec_q.shamt,
                            out_rec_q.flag_b,
                            out_rec_q.flag_a,
                            out_rec_q.shift_sel,
                            out_rec_q.sub_op,
                            out_rec_q.immediate,
                            out_rec_q.ra,
                            out_rec_q.rm,
                            out_rec_q.rn,
                            out_rec_q.rd,
                            out_rec_q.wide};

  // An accepted input beat occupies the word register on the next cycle
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat did not reach the word register");

  // A word that advances must show up as a result beat
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> m_axis_tvalid_o)
    else $error("decoded word lost between stages");

  // A stalled word register keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q && $stable(s1_word_q))
    else $error("stalled word register changed");

  // Invalid and nop results carry all-zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_INVALID || m_axis_tuser_o == KIND_NOP)
      |-> m_axis_tdata_o == '0)
    else $error("invalid or nop result has nonzero fields");

endmodule

// File: tb/a64d_decode_checker.sv
// Decode checker: predicts each decode record from the accepted word and compares result beats.
module a64d_decode_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // tdata: instr_word[31:0]
  input  logic [a64d_pkg::InstrW-1:0]   s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // tdata: wide[0], rd[5:1], rn[10:6], rm[15:11], ra[20:16], immediate[46:21],
  //        sub_op[50:47], shift_sel[52:51], flag_a[53], flag_b[54],
  //        shamt[60:55], zero fill[63:61]
  input  logic [a64d_pkg::TdataOW-1:0]  m_axis_tdata_i,
  // tuser: kind[3:0]
  input  logic [a64d_pkg::KindW-1:0]    m_axis_tuser_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import a64d_pkg::*;

  // Major class patterns and sub-opcodes of the decoded subset
  localparam logic [2:0] ClsDpImm    = 3'b100;  // bits 28:26
  localparam logic [2:0] ClsDpReg    = 3'b101;  // bits 27:25
  localparam logic [2:0] ClsBranch   = 3'b101;  // bits 28:26
  localparam logic [2:0] OpAddImm    = 3'b010;  // bits 25:23
  localparam logic [2:0] OpMovWide   = 3'b101;  // bits 25:23
  localparam logic [2:0] BrOpCond    = 3'b010;  // bits 31:29
  localparam logic [2:0] BrOpReg     = 3'b110;  // bits 31:29
  localparam logic [1:0] BrOpImmLow  = 2'b00;   // bits 30:29
  localparam logic [1:0] LsOp0Lit    = 2'b01;   // bits 29:28
  localparam logic [1:0] LsOp0Reg    = 2'b11;   // bits 29:28
  localparam logic [1:0] LsOp4RegOff = 2'b10;   // bits 11:10
  localparam logic [1:0] LsOp2Post   = 2'b10;   // bits 24:23

  typedef struct {
    logic [InstrW-1:0] word;
    a64d_rec_t         rec;
  } decode_exp_t;

  decode_exp_t expected_decodes[$];

  // Classify the word, then pull the fields that its kind defines; the rest stay zero
  function automatic a64d_rec_t decode_word(input logic [InstrW-1:0] w);
    a64d_rec_t  r;
    a64d_kind_e k;
    r = '0;
    k = KIND_INVALID;
    if (w == NopWord) begin
      k = KIND_NOP;
    end else if (w[28:26] == ClsDpImm) begin
      if (w[25:23] == OpAddImm) k = KIND_ADDIMM;
      else if (w[25:23] == OpMovWide) k = KIND_MOVWIDE;
    end else if (w[27:25] == ClsDpReg) begin
      if (w[28] && w[24]) k = KIND_MUL;
      else if (!w[28] && !w[24]) k = KIND_LOGREG;
      else if (!w[21] && w[24]) k = KIND_ADDREG;
    end else if (w[28:26] == ClsBranch) begin
      if (w[31:29] == BrOpCond) k = KIND_BCOND;
      else if (w[30:29] == BrOpImmLow) k = KIND_BIMM;
      else if (w[31:29] == BrOpReg) k = KIND_BREG;
    end else if (!w[25] && w[27]) begin
      if (w[29:28] == LsOp0Lit && !w[24]) k = KIND_LDLIT;
      else if (w[29:28] == LsOp0Reg && w[11:10] == LsOp4RegOff && w[21] && !w[24])
        k = KIND_LSREG;
      else if (w[29:28] == LsOp0Reg && w[24]) k = KIND_LSUIMM;
      else if (w[29:28] == LsOp0Reg && w[24:23] != LsOp2Post && !w[21]) k = KIND_LSSIMM;
    end
    r.kind = k;
    case (k)
      KIND_ADDIMM: begin
        r.wide      = w[31];
        r.rd        = w[4:0];
        r.rn        = w[9:5];
        r.flag_a    = w[30];
        r.flag_b    = w[29];
        r.shift_sel = {1'b0, w[22]};
        r.immediate = ImmW'(w[21:10]);
      end
      KIND_MOVWIDE: begin
        r.wide      = w[31];
        r.rd        = w[4:0];
        r.immediate = ImmW'(w[20:5]);
        r.sub_op    = SubOpW'(w[30:29]);
        r.shift_sel = w[22:21];
      end
      KIND_LOGREG: begin
        r.wide      = w[31];
        r.rd        = w[4:0];
        r.rn        = w[9:5];
        r.rm        = w[20:16];
        r.sub_op    = SubOpW'(w[30:29]);
        r.flag_a    = w[21];
        r.shift_sel = w[23:22];
        r.shamt     = w[15:10];
      end
      KIND_ADDREG: begin
        r.wide      = w[31];
        r.rd        = w[4:0];
        r.rn        = w[9:5];
        r.rm        = w[20:16];
        r.flag_a    = w[30];
        r.flag_b    = w[29];
        r.shift_sel = w[23:22];
        r.shamt     = w[15:10];
      end
      KIND_MUL: begin
        r.wide   = w[31];
        r.rd     = w[4:0];
        r.rn     = w[9:5];
        r.rm     = w[20:16];
        r.ra     = w[14:10];
        r.flag_a = w[15];
      end
      KIND_BIMM: r.immediate = w[25:0];
      KIND_BCOND: begin
        r.sub_op    = w[3:0];
        r.immediate = ImmW'(w[23:5]);
      end
      KIND_BREG: r.rn = w[9:5];
      KIND_LDLIT: begin
        r.wide      = w[30];
        r.rd        = w[4:0];
        r.immediate = ImmW'(w[23:5]);
      end
      KIND_LSREG: begin
        r.wide   = w[30];
        r.rd     = w[4:0];
        r.rn     = w[9:5];
        r.rm     = w[20:16];
        r.sub_op = SubOpW'(w[15:13]);
        r.flag_b = w[12];
        r.flag_a = w[22];
      end
      KIND_LSUIMM: begin
        r.wide      = w[30];
        r.rd        = w[4:0];
        r.rn        = w[9:5];
        r.immediate = ImmW'(w[21:10]);
        r.flag_a    = w[22];
      end
      KIND_LSSIMM: begin
        r.wide      = w[30];
        r.rd        = w[4:0];
        r.rn        = w[9:5];
        r.immediate = ImmW'(w[20:12]);
        r.flag_a    = w[22];
        r.shift_sel = w[11:10];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_failure(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input logic [InstrW-1:0] word);
    if (got !== want)
      report_failure($sformatf("word %h: %s got %h expected %h", word, name, got, want));
  endtask

  // Compare one result beat against the oldest predicted decode
  task automatic compare_beat(input decode_exp_t e, input logic [TdataOW-1:0] d,
                              input logic [KindW-1:0] u);
    check_field("kind", 32'(u), 32'(e.rec.kind), e.word);
    check_field("wide", 32'(d[0]), 32'(e.rec.wide), e.word);
    check_field("rd", 32'(d[5:1]), 32'(e.rec.rd), e.word);
    check_field("rn", 32'(d[10:6]), 32'(e.rec.rn), e.word);
    check_field("rm", 32'(d[15:11]), 32'(e.rec.rm), e.word);
    check_field("ra", 32'(d[20:16]), 32'(e.rec.ra), e.word);
    check_field("immediate", 32'(d[46:21]), 32'(e.rec.immediate), e.word);
    check_field("sub_op", 32'(d[50:47]), 32'(e.rec.sub_op), e.word);
    check_field("shift_sel", 32'(d[52:51]), 32'(e.rec.shift_sel), e.word);
    check_field("flag_a", 32'(d[53]), 32'(e.rec.flag_a), e.word);
    check_field("flag_b", 32'(d[54]), 32'(e.rec.flag_b), e.word);
    check_field("shamt", 32'(d[60:55]), 32'(e.rec.shamt), e.word);
    check_field("zero fill", 32'(d[63:61]), '0, e.word);
  endtask

  // Predict on every accepted word, check on every accepted result beat
  always @(posedge clk_i) begin
    decode_exp_t e;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        e.word = s_axis_tdata_i;
        e.rec  = decode_word(s_axis_tdata_i);
        expected_decodes.push_back(e);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_decodes.size() == 0) begin
          report_failure($sformatf("result beat kind %h data %h with no decode pending",
                                   m_axis_tuser_i, m_axis_tdata_i));
        end else begin
          e = expected_decodes.pop_front();
          compare_beat(e, m_axis_tdata_i, m_axis_tuser_i);
        end
      end
      pending_o = expected_decodes.size();
    end
  end

endmodule

// File: tb/tb_arm64_subset_instruction_decoder_unit.sv
// Testbench top: clock, reset, instruction word stimulus, result backpressure and verdict.
module tb_arm64_subset_instruction_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import a64d_pkg::*;

  localparam int HalfPeriod   = 2;        // 4 ns clock
  localparam int ResetCycles  = 12;
  localparam int DrainCycles  = 8;
  localparam int PhaseItems   = 450;
  localparam int TemplateCnt  = 13;
  localparam int LimitCycles  = 400_000;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InstrW-1:0]   s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [TdataOW-1:0]  m_axis_tdata_o;
  logic [KindW-1:0]    m_axis_tuser_o;

  int unsigned fail_count;
  int unsigned pending_decodes;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  arm64_subset_instruction_decoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  a64d_decode_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_decodes)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Stall the result side at the rate of the current phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Force the opcode bits of one encoding class onto a word, keep the rest
  function automatic logic [InstrW-1:0] shape_word(input int idx, input logic [InstrW-1:0] raw);
    logic [InstrW-1:0] mask;
    logic [InstrW-1:0] value;
    case (idx)
      0:  begin mask = 32'h1F80_0000; value = 32'h1100_0000; end  // add/sub immediate
      1:  begin mask = 32'h1F80_0000; value = 32'h1280_0000; end  // move wide
      2:  begin mask = 32'h1F80_0000; value = 32'h1200_0000; end  // logical immediate
      3:  begin mask = 32'h1F00_0000; value = 32'h0A00_0000; end  // logical register
      4:  begin mask = 32'h1F20_0000; value = 32'h0B00_0000; end  // add/sub register
      5:  begin mask = 32'h1F00_0000; value = 32'h1B00_0000; end  // multiply
      6:  begin mask = 32'h7C00_0000; value = 32'h1400_0000; end  // branch immediate
      7:  begin mask = 32'hFC00_0000; value = 32'h5400_0000; end  // conditional branch
      8:  begin mask = 32'hFC00_0000; value = 32'hD400_0000; end  // register branch
      9:  begin mask = 32'h3B00_0000; value = 32'h1800_0000; end  // load literal
      10: begin mask = 32'h3B20_0C00; value = 32'h3820_0800; end  // register offset
      11: begin mask = 32'h3B00_0000; value = 32'h3900_0000; end  // unsigned offset
      default: begin mask = 32'h3B20_0000; value = 32'h3800_0000; end  // signed offset
    endcase
    return (raw & ~mask) | value;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [InstrW-1:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Mostly well-formed class words, some near-nop words, some raw noise
  function automatic logic [InstrW-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return shape_word($urandom_range(0, TemplateCnt - 1), $urandom);
    if (pick < 80) return NopWord;
    if (pick < 88) return NopWord ^ (32'h1 << $urandom_range(0, InstrW - 1));
    return $urandom;
  endfunction

  // Hold reset, run directed words and three random phases (the last with no idling), drain and judge
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 34; recv_stall_pct = 71; end
        1: begin send_idle_pct = 71; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 0) begin
        // each class with its free bits all low and all high, plus the exact nop
        send_word(NopWord);
        for (int t = 0; t < TemplateCnt; t++) begin
          send_word(shape_word(t, '0));
          send_word(shape_word(t, '1));
        end
      end
      for (int n = 0; n < PhaseItems; n++) send_word(random_word());
    end
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_decodes != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
